[rtl/core/cvc_pkg.sv]
// Shared constants, codes and helpers for the chunk view culling block.
`default_nettype none

package cvc_pkg;

    // Port level widths
    localparam int COORD_W     = 11;
    localparam int COMP_W      = 20;
    localparam int VEC_W       = 3 * COMP_W;
    localparam int DIST_W      = 17;
    localparam int LEN_W       = 15;
    localparam int RAD_W       = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int PIPE_DEPTH  = 7;

    // Datapath widths
    localparam int CENTRE_W   = COORD_W + LEN_W + 1;   // coord * length
    localparam int DIFF_W     = CENTRE_W + 1;          // centre - viewer
    localparam int W_W        = COMP_W + DIST_W + 1;   // backward * clamp distance
    localparam int BB_W       = 2 * COMP_W;            // backward squared
    localparam int WB_W       = BB_W + DIST_W + 1;     // backward^2 * clamp distance
    localparam int DD_W       = 2 * DIFF_W;
    localparam int DSUM_W     = DD_W + 2;
    localparam int PN_W       = COMP_W + DIFF_W;
    localparam int PSUM_W     = PN_W + 3;
    localparam int E_W        = DIFF_W + 2;            // 2*d +/- length
    localparam int EB_W       = E_W + COMP_W;
    localparam int HALF_SH    = 17;                    // half edge scale, 2^17
    localparam int UNIT_SH    = 18;                    // Q8 -> Q26 scale, 2^18
    localparam int CMP_W      = E_W + HALF_SH;
    localparam int TERM_W     = EB_W + HALF_SH;
    localparam int TSUM_W     = TERM_W + 2;
    localparam int REACH_W    = DIST_W + 1;
    localparam int REACH_SQ_W = 2 * REACH_W;
    localparam int SQ_W       = 32;                    // 3*L*L fits 32 bits

    localparam logic [DIST_W-1:0] VIEW_DIST_RESET = DIST_W'(25600);
    localparam logic [LEN_W-1:0]  CHUNK_LEN_RESET = LEN_W'(4096);
    localparam logic [DIST_W-1:0] MIN_CLAMP_DIST  = DIST_W'(256);
    localparam logic [SQ_W-1:0]   SQ_FIRST_BIT    = SQ_W'(32'h4000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEWER_POS = 3'd0,
        CFG_BACKWARD   = 3'd1,
        CFG_RIGHT      = 3'd2,
        CFG_LEFT       = 3'd3,
        CFG_TOP        = 3'd4,
        CFG_BOTTOM     = 3'd5,
        CFG_VIEW_DIST  = 3'd6,
        CFG_CHUNK_LEN  = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        REASON_VISIBLE = 2'd0,
        REASON_RANGE   = 2'd1,
        REASON_BEHIND  = 2'd2,
        REASON_FRUSTUM = 2'd3
    } cull_reason_t;

    // One signed 20-bit component of a packed x/y/z vector
    function automatic logic signed [COMP_W-1:0] vec_comp(input logic [VEC_W-1:0] v,
                                                          input int unsigned idx);
        return $signed(v[idx*COMP_W +: COMP_W]);
    endfunction

endpackage

`default_nettype wire

[rtl/core/chunk_view_culling.sv]
// Chunk view culling: sphere range, behind-viewer and frustum side-plane tests.
`default_nettype none

// Streams chunk grid coordinates in and one visible/reason result per chunk out.
// Throughput is one chunk per clock while s_tready is high. The pipeline
// holds seven register stages (input register plus six arithmetic stages,
// each about one multiplier deep). Any stage that holds a bubble absorbs a
// stall, so the input keeps taking transfers while a result waits on m_tready.
// The chunk radius, floor(sqrt(3)*L/2), comes from a square root unit that
// retires one root bit per cycle: after reset and after every chunk_length
// write it runs, and s_tready is low while it does. Configuration writes are
// always taken (cfg_ready high) and must only be issued while no chunk is in
// flight.
module chunk_view_culling (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input chunk stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [cvc_pkg::IN_TDATA_W-1:0]   s_tdata,   // chunk_x, chunk_y, chunk_z, pad
    // result stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [cvc_pkg::OUT_TDATA_W-1:0]       m_tdata,   // visible, cull_reason, pad
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [cvc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cvc_pkg::VEC_W-1:0]        cfg_data
);

    localparam int NAX = 3;   // axes
    localparam int NPL = 4;   // side planes

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cvc_pkg::VEC_W-1:0]  viewer_pos_reg;
    logic [cvc_pkg::VEC_W-1:0]  backward_reg;
    logic [cvc_pkg::VEC_W-1:0]  plane_reg [0:NPL-1];   // right, left, top, bottom
    logic [cvc_pkg::DIST_W-1:0] view_dist_reg;
    logic [cvc_pkg::LEN_W-1:0]  chunk_len_reg;

    logic cfg_xfer;
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            viewer_pos_reg <= '0;
            backward_reg   <= '0;
            for (int p = 0; p < NPL; p++) begin
                plane_reg[p] <= '0;
            end
            view_dist_reg  <= cvc_pkg::VIEW_DIST_RESET;
            chunk_len_reg  <= cvc_pkg::CHUNK_LEN_RESET;
        end else if (cfg_xfer) begin
            unique case (cvc_pkg::cfg_index_t'(cfg_index))
                cvc_pkg::CFG_VIEWER_POS: viewer_pos_reg <= cfg_data;
                cvc_pkg::CFG_BACKWARD:   backward_reg   <= cfg_data;
                cvc_pkg::CFG_RIGHT:      plane_reg[0]   <= cfg_data;
                cvc_pkg::CFG_LEFT:       plane_reg[1]   <= cfg_data;
                cvc_pkg::CFG_TOP:        plane_reg[2]   <= cfg_data;
                cvc_pkg::CFG_BOTTOM:     plane_reg[3]   <= cfg_data;
                cvc_pkg::CFG_VIEW_DIST:  view_dist_reg  <= cfg_data[cvc_pkg::DIST_W-1:0];
                cvc_pkg::CFG_CHUNK_LEN:  chunk_len_reg  <= cfg_data[cvc_pkg::LEN_W-1:0];
            endcase
        end
    end

    // Unpacked vector components
    logic signed [cvc_pkg::COMP_W-1:0] vp_comp  [0:NAX-1];
    logic signed [cvc_pkg::COMP_W-1:0] bk_comp  [0:NAX-1];
    logic signed [cvc_pkg::COMP_W-1:0] nrm_comp [0:NPL-1][0:NAX-1];

    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            vp_comp[i] = cvc_pkg::vec_comp(viewer_pos_reg, i);
            bk_comp[i] = cvc_pkg::vec_comp(backward_reg, i);
            for (int p = 0; p < NPL; p++) begin
                nrm_comp[p][i] = cvc_pkg::vec_comp(plane_reg[p], i);
            end
        end
    end

    // Clamp distance used for the behind-viewer point
    logic [cvc_pkg::DIST_W-1:0] vdc;
    assign vdc = (view_dist_reg > cvc_pkg::MIN_CLAMP_DIST) ? view_dist_reg
                                                           : cvc_pkg::MIN_CLAMP_DIST;

    // ------------------------------------------------------------------
    // Radius unit: isqrt(3*L*L) >> 1, one root bit per cycle
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        SQ_LOAD,
        SQ_RUN,
        SQ_IDLE
    } sq_state_t;

    sq_state_t                       sq_state_reg;
    logic [cvc_pkg::SQ_W-1:0]        sq_x_reg;
    logic [cvc_pkg::SQ_W-1:0]        sq_res_reg;
    logic [cvc_pkg::SQ_W-1:0]        sq_bit_reg;
    logic [cvc_pkg::RAD_W-1:0]       radius_reg;

    logic [2*cvc_pkg::LEN_W-1:0]     len_sq;
    logic [cvc_pkg::SQ_W-1:0]        len_sq3;
    logic [cvc_pkg::SQ_W:0]          sq_trial;
    logic                            sq_take;
    logic [cvc_pkg::SQ_W-1:0]        sq_res_next;
    logic                            sq_ready;

    assign len_sq      = chunk_len_reg * chunk_len_reg;
    assign len_sq3     = {2'b00, len_sq} + {1'b0, len_sq, 1'b0};
    assign sq_trial    = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
    assign sq_take     = {1'b0, sq_x_reg} >= sq_trial;
    assign sq_res_next = sq_take ? ((sq_res_reg >> 1) + sq_bit_reg) : (sq_res_reg >> 1);
    assign sq_ready    = (sq_state_reg == SQ_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_state_reg <= SQ_LOAD;
            radius_reg   <= '0;
        end else if (cfg_xfer && (cfg_index == cvc_pkg::CFG_CHUNK_LEN)) begin
            sq_state_reg <= SQ_LOAD;     // new length lands this edge
        end else begin
            unique case (sq_state_reg)
                SQ_LOAD: begin
                    sq_x_reg     <= len_sq3;
                    sq_res_reg   <= '0;
                    sq_bit_reg   <= cvc_pkg::SQ_FIRST_BIT;
                    sq_state_reg <= SQ_RUN;
                end
                SQ_RUN: begin
                    if (sq_take) begin
                        sq_x_reg <= sq_x_reg - sq_trial[cvc_pkg::SQ_W-1:0];
                    end
                    sq_res_reg <= sq_res_next;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        radius_reg   <= sq_res_next[cvc_pkg::RAD_W:1];
                        sq_state_reg <= SQ_IDLE;
                    end
                end
                SQ_IDLE: begin
                end
                default: sq_state_reg <= SQ_LOAD;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when the next
    // stage loads.
    // ------------------------------------------------------------------
    logic [cvc_pkg::PIPE_DEPTH:1] valid_reg;
    logic [cvc_pkg::PIPE_DEPTH:1] stage_en;

    always_comb begin
        stage_en[cvc_pkg::PIPE_DEPTH] = !valid_reg[cvc_pkg::PIPE_DEPTH] || m_tready;
        for (int k = cvc_pkg::PIPE_DEPTH - 1; k >= 1; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[1] && sq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[1]) begin
                valid_reg[1] <= s_tvalid && s_tready;
            end
            for (int k = 2; k <= cvc_pkg::PIPE_DEPTH; k++) begin
                if (stage_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers, by stage
    // ------------------------------------------------------------------
    // S1: input coordinates
    logic signed [cvc_pkg::COORD_W-1:0]  cx1_reg      [0:NAX-1];
    // S2: centre, backward products, reach
    logic signed [cvc_pkg::CENTRE_W-1:0] centre2_reg  [0:NAX-1];
    logic signed [cvc_pkg::BB_W-1:0]     bb2_reg      [0:NAX-1];
    logic signed [cvc_pkg::W_W-1:0]      w2_reg       [0:NAX-1];
    logic [cvc_pkg::REACH_W-1:0]         reach2_reg;
    // S3: offset from viewer, vdc * backward^2, reach^2
    logic signed [cvc_pkg::DIFF_W-1:0]   d3_reg       [0:NAX-1];
    logic signed [cvc_pkg::WB_W-1:0]     wb3_reg      [0:NAX-1];
    logic signed [cvc_pkg::W_W-1:0]      w3_reg       [0:NAX-1];
    logic [cvc_pkg::REACH_SQ_W-1:0]      reach_sq3_reg;
    // S4: squares, plane products, clamp side, box faces
    logic signed [cvc_pkg::DD_W-1:0]     dd4_reg      [0:NAX-1];
    logic signed [cvc_pkg::PN_W-1:0]     pn4_reg      [0:NPL-1][0:NAX-1];
    logic [NAX-1:0]                      lt4_reg;
    logic signed [cvc_pkg::E_W-1:0]      e_hi4_reg    [0:NAX-1];
    logic signed [cvc_pkg::E_W-1:0]      e_lo4_reg    [0:NAX-1];
    logic signed [cvc_pkg::W_W-1:0]      w4_reg       [0:NAX-1];
    logic signed [cvc_pkg::WB_W-1:0]     wb4_reg      [0:NAX-1];
    logic [cvc_pkg::REACH_SQ_W-1:0]      reach_sq4_reg;
    // S5: range and frustum flags, clamp choice
    logic                                far5_reg;
    logic                                frustum5_reg;
    logic [NAX-1:0]                      sel_w5_reg;
    logic signed [cvc_pkg::E_W-1:0]      e5_reg       [0:NAX-1];
    logic signed [cvc_pkg::WB_W-1:0]     wb5_reg      [0:NAX-1];
    // S6: behind-viewer dot terms
    logic signed [cvc_pkg::TERM_W-1:0]   term6_reg    [0:NAX-1];
    logic                                far6_reg;
    logic                                frustum6_reg;
    // S7: result
    logic                                visible7_reg;
    cvc_pkg::cull_reason_t               reason7_reg;

    // Stage logic
    logic signed [cvc_pkg::CENTRE_W-1:0] centre_next  [0:NAX-1];
    logic signed [cvc_pkg::BB_W-1:0]     bb_next      [0:NAX-1];
    logic signed [cvc_pkg::W_W-1:0]      w_next       [0:NAX-1];
    logic [cvc_pkg::REACH_W-1:0]         reach_next;
    logic signed [cvc_pkg::DIFF_W-1:0]   d_next       [0:NAX-1];
    logic signed [cvc_pkg::WB_W-1:0]     wb_next      [0:NAX-1];
    logic [cvc_pkg::REACH_SQ_W-1:0]      reach_sq_next;
    logic signed [cvc_pkg::DD_W-1:0]     dd_next      [0:NAX-1];
    logic signed [cvc_pkg::PN_W-1:0]     pn_next      [0:NPL-1][0:NAX-1];
    logic [NAX-1:0]                      lt_next;
    logic signed [cvc_pkg::E_W-1:0]      e_hi_next    [0:NAX-1];
    logic signed [cvc_pkg::E_W-1:0]      e_lo_next    [0:NAX-1];
    logic signed [cvc_pkg::DSUM_W-1:0]   dsum;
    logic signed [cvc_pkg::PSUM_W-1:0]   psum         [0:NPL-1];
    logic signed [cvc_pkg::PSUM_W-1:0]   rq_ext;
    logic                                far_next;
    logic                                frustum_next;
    logic [NAX-1:0]                      sel_w_next;
    logic signed [cvc_pkg::E_W-1:0]      e_next       [0:NAX-1];
    logic signed [cvc_pkg::CMP_W-1:0]    w_cmp        [0:NAX-1];
    logic signed [cvc_pkg::EB_W-1:0]     eb           [0:NAX-1];
    logic signed [cvc_pkg::TERM_W-1:0]   term_next    [0:NAX-1];
    logic signed [cvc_pkg::TSUM_W-1:0]   tsum;
    logic                                behind;
    cvc_pkg::cull_reason_t               reason_next;

    // S2: world centre = coord * L; backward^2; backward * clamp distance; reach
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            centre_next[i] = cx1_reg[i] * $signed({1'b0, chunk_len_reg});
            bb_next[i]     = bk_comp[i] * bk_comp[i];
            w_next[i]      = bk_comp[i] * $signed({1'b0, vdc});
        end
        reach_next = {1'b0, view_dist_reg}
                   + {{(cvc_pkg::REACH_W-cvc_pkg::RAD_W){1'b0}}, radius_reg};
    end

    // S3: offset d = centre - viewer; vdc * backward^2; reach^2
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            d_next[i]  = $signed({centre2_reg[i][cvc_pkg::CENTRE_W-1], centre2_reg[i]})
                       - $signed({{(cvc_pkg::DIFF_W-cvc_pkg::COMP_W){vp_comp[i][cvc_pkg::COMP_W-1]}},
                                  vp_comp[i]});
            wb_next[i] = bb2_reg[i] * $signed({1'b0, vdc});
        end
        reach_sq_next = reach2_reg * reach2_reg;
    end

    // S4: d^2, plane dots, which side of the clamp point, box faces
    // Box face offsets in Q26 are 2^17 * (2d +/- L).
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            dd_next[i] = d3_reg[i] * d3_reg[i];
            for (int p = 0; p < NPL; p++) begin
                pn_next[p][i] = nrm_comp[p][i] * d3_reg[i];
            end
            lt_next[i]   = $signed({d3_reg[i][cvc_pkg::DIFF_W-1], d3_reg[i],
                                    {cvc_pkg::UNIT_SH{1'b0}}})
                         < $signed(cvc_pkg::CMP_W'(w3_reg[i]));
            e_hi_next[i] = $signed({d3_reg[i][cvc_pkg::DIFF_W-1], d3_reg[i], 1'b0})
                         + $signed({{(cvc_pkg::E_W-cvc_pkg::LEN_W){1'b0}}, chunk_len_reg});
            e_lo_next[i] = $signed({d3_reg[i][cvc_pkg::DIFF_W-1], d3_reg[i], 1'b0})
                         - $signed({{(cvc_pkg::E_W-cvc_pkg::LEN_W){1'b0}}, chunk_len_reg});
        end
    end

    // S5: range test, side-plane tests, clamp selection per axis
    always_comb begin
        dsum = cvc_pkg::DSUM_W'(dd4_reg[0]) + cvc_pkg::DSUM_W'(dd4_reg[1])
             + cvc_pkg::DSUM_W'(dd4_reg[2]);
        far_next = dsum > $signed(cvc_pkg::DSUM_W'(reach_sq4_reg));

        rq_ext = $signed(cvc_pkg::PSUM_W'({radius_reg, {cvc_pkg::UNIT_SH{1'b0}}}));
        frustum_next = 1'b0;
        for (int p = 0; p < NPL; p++) begin
            psum[p] = cvc_pkg::PSUM_W'(pn4_reg[p][0]) + cvc_pkg::PSUM_W'(pn4_reg[p][1])
                    + cvc_pkg::PSUM_W'(pn4_reg[p][2]) + rq_ext;
            frustum_next = frustum_next | psum[p][cvc_pkg::PSUM_W-1];
        end

        // sel_w: the clamp point itself is nearer than the box face
        for (int i = 0; i < NAX; i++) begin
            w_cmp[i] = cvc_pkg::CMP_W'(w4_reg[i]);
            if (lt4_reg[i]) begin
                sel_w_next[i] = $signed({e_hi4_reg[i], {cvc_pkg::HALF_SH{1'b0}}}) > w_cmp[i];
                e_next[i]     = e_hi4_reg[i];
            end else begin
                sel_w_next[i] = $signed({e_lo4_reg[i], {cvc_pkg::HALF_SH{1'b0}}}) < w_cmp[i];
                e_next[i]     = e_lo4_reg[i];
            end
        end
    end

    // S6: per-axis term of dot(clamped - viewer, backward)
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            eb[i]        = e5_reg[i] * bk_comp[i];
            term_next[i] = sel_w5_reg[i] ? cvc_pkg::TERM_W'(wb5_reg[i])
                                         : $signed({eb[i], {cvc_pkg::HALF_SH{1'b0}}});
        end
    end

    // S7: first failing test decides the reason
    always_comb begin
        tsum = cvc_pkg::TSUM_W'(term6_reg[0]) + cvc_pkg::TSUM_W'(term6_reg[1])
             + cvc_pkg::TSUM_W'(term6_reg[2]);
        behind = tsum[cvc_pkg::TSUM_W-1] || (tsum == '0);
        priority if (far6_reg) begin
            reason_next = cvc_pkg::REASON_RANGE;
        end else if (behind) begin
            reason_next = cvc_pkg::REASON_BEHIND;
        end else if (frustum6_reg) begin
            reason_next = cvc_pkg::REASON_FRUSTUM;
        end else begin
            reason_next = cvc_pkg::REASON_VISIBLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int i = 0; i < NAX; i++) begin
                cx1_reg[i] <= $signed(s_tdata[i*cvc_pkg::COORD_W +: cvc_pkg::COORD_W]);
            end
        end
        if (stage_en[2]) begin
            for (int i = 0; i < NAX; i++) begin
                centre2_reg[i] <= centre_next[i];
                bb2_reg[i]     <= bb_next[i];
                w2_reg[i]      <= w_next[i];
            end
            reach2_reg <= reach_next;
        end
        if (stage_en[3]) begin
            for (int i = 0; i < NAX; i++) begin
                d3_reg[i]  <= d_next[i];
                wb3_reg[i] <= wb_next[i];
                w3_reg[i]  <= w2_reg[i];
            end
            reach_sq3_reg <= reach_sq_next;
        end
        if (stage_en[4]) begin
            for (int i = 0; i < NAX; i++) begin
                dd4_reg[i]   <= dd_next[i];
                for (int p = 0; p < NPL; p++) begin
                    pn4_reg[p][i] <= pn_next[p][i];
                end
                e_hi4_reg[i] <= e_hi_next[i];
                e_lo4_reg[i] <= e_lo_next[i];
                w4_reg[i]    <= w3_reg[i];
                wb4_reg[i]   <= wb3_reg[i];
            end
            lt4_reg       <= lt_next;
            reach_sq4_reg <= reach_sq3_reg;
        end
        if (stage_en[5]) begin
            far5_reg     <= far_next;
            frustum5_reg <= frustum_next;
            sel_w5_reg   <= sel_w_next;
            for (int i = 0; i < NAX; i++) begin
                e5_reg[i]  <= e_next[i];
                wb5_reg[i] <= wb4_reg[i];
            end
        end
        if (stage_en[6]) begin
            for (int i = 0; i < NAX; i++) begin
                term6_reg[i] <= term_next[i];
            end
            far6_reg     <= far5_reg;
            frustum6_reg <= frustum5_reg;
        end
        if (stage_en[7]) begin
            reason7_reg  <= reason_next;
            visible7_reg <= (reason_next == cvc_pkg::REASON_VISIBLE);
        end
    end

    assign m_tvalid = valid_reg[cvc_pkg::PIPE_DEPTH];
    assign m_tdata  = {{(cvc_pkg::OUT_TDATA_W-3){1'b0}}, reason7_reg, visible7_reg};

endmodule

`default_nettype wire

[rtl/core/cvc_checker.sv]
// Port-level checks for chunk_view_culling and the bind that attaches them.
`default_nettype none

module cvc_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [cvc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // chunks taken but not yet delivered
    logic [3:0] outstanding_reg;
    logic       s_xfer;
    logic       m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= '0;
        end else begin
            outstanding_reg <= outstanding_reg + {3'b000, s_xfer} - {3'b000, m_xfer};
        end
    end

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    a_flag_matches_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == cvc_pkg::REASON_VISIBLE))
                     && (m_tdata[cvc_pkg::OUT_TDATA_W-1:3] == '0))
        else $error("visible flag disagrees with cull reason");

    a_no_invented_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (outstanding_reg != '0))
        else $error("result offered with no chunk in flight");

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        outstanding_reg <= 4'(cvc_pkg::PIPE_DEPTH))
        else $error("more chunks in flight than pipeline stages");

endmodule

bind chunk_view_culling cvc_checker u_cvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[tb/sv/chunk_view_culling_test.sv]
// Self-checking stream testbench for the chunk view culling block.
`timescale 1ns / 100ps

module chunk_view_culling_test;

    // Q8 world units to the Q26 scale used by the behind-viewer and frustum tests
    localparam longint UNIT_SCALE = longint'(1) << cvc_pkg::UNIT_SH;
    // half chunk edge in Q26 is the Q8 length times 2^17
    localparam longint HALF_SCALE = longint'(1) << cvc_pkg::HALF_SH;
    localparam real    DEG        = 3.14159265358979 / 180.0;
    localparam int     RANDOM_CHUNKS = 1300;

    // One verdict per chunk: the visible flag and the reason code
    typedef struct packed {
        logic                  visible;
        cvc_pkg::cull_reason_t reason;
    } verdict_t;

    // Mirror of the register file plus the in-order store of predicted verdicts.
    class chunk_verdict_scoreboard;
        logic [cvc_pkg::VEC_W-1:0]  viewer_pos;
        logic [cvc_pkg::VEC_W-1:0]  backward;
        logic [cvc_pkg::VEC_W-1:0]  plane_normal [4];   // right, left, top, bottom
        logic [cvc_pkg::DIST_W-1:0] view_dist;
        logic [cvc_pkg::LEN_W-1:0]  chunk_len;
        verdict_t                   pending_verdicts [$];
        int                         errors;
        int                         results_seen;

        function new();
            viewer_pos = '0;
            backward   = '0;
            foreach (plane_normal[k]) plane_normal[k] = '0;
            view_dist    = cvc_pkg::VIEW_DIST_RESET;
            chunk_len    = cvc_pkg::CHUNK_LEN_RESET;
            errors       = 0;
            results_seen = 0;
        endfunction

        static function longint component(logic [cvc_pkg::VEC_W-1:0] vec, int axis);
            logic signed [cvc_pkg::COMP_W-1:0] part;
            part = cvc_pkg::COMP_W'(vec >> (axis * cvc_pkg::COMP_W));
            return part;
        endfunction

        // floor(sqrt(x)) for x below 2^32, by bisection
        static function longint floor_sqrt(longint x);
            longint lo, hi, mid;
            lo = 0;
            hi = 65536;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid <= x) lo = mid;
                else hi = mid;
            end
            return lo;
        endfunction

        function void set_register(cvc_pkg::cfg_index_t idx, logic [cvc_pkg::VEC_W-1:0] value);
            case (idx)
                cvc_pkg::CFG_VIEWER_POS: viewer_pos      = value;
                cvc_pkg::CFG_BACKWARD:   backward        = value;
                cvc_pkg::CFG_RIGHT:      plane_normal[0] = value;
                cvc_pkg::CFG_LEFT:       plane_normal[1] = value;
                cvc_pkg::CFG_TOP:        plane_normal[2] = value;
                cvc_pkg::CFG_BOTTOM:     plane_normal[3] = value;
                cvc_pkg::CFG_VIEW_DIST:  view_dist       = value[cvc_pkg::DIST_W-1:0];
                cvc_pkg::CFG_CHUNK_LEN:  chunk_len       = value[cvc_pkg::LEN_W-1:0];
                default: ;
            endcase
        endfunction

        function verdict_t cull_chunk(logic [cvc_pkg::COORD_W-1:0] cx,
                                      logic [cvc_pkg::COORD_W-1:0] cy,
                                      logic [cvc_pkg::COORD_W-1:0] cz);
            logic [cvc_pkg::COORD_W-1:0] grid [3];
            longint eye [3];
            longint back [3];
            longint centre [3];
            longint d [3];
            longint rel [3];
            longint len, vd, radius, reach, dist_sq, half, clamp_dist, facing, rq, lean;
            longint c, v, p, pos;
            verdict_t result;
            grid[0] = cx;
            grid[1] = cy;
            grid[2] = cz;
            len    = longint'(chunk_len);
            vd     = longint'(view_dist);
            radius = floor_sqrt(3 * len * len) / 2;
            for (int a = 0; a < 3; a++) begin
                eye[a]    = component(viewer_pos, a);
                back[a]   = component(backward, a);
                centre[a] = longint'($signed(grid[a])) * len;
                d[a]      = centre[a] - eye[a];
            end
            result.visible = 1'b0;

            reach   = vd + radius;
            dist_sq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
            if (dist_sq > reach * reach) begin
                result.reason = cvc_pkg::REASON_RANGE;
                return result;
            end

            // clamp the chunk box toward the point behind the viewer, per axis
            half       = len * HALF_SCALE;
            clamp_dist = (vd > longint'(cvc_pkg::MIN_CLAMP_DIST)) ? vd
                                                                  : longint'(cvc_pkg::MIN_CLAMP_DIST);
            for (int a = 0; a < 3; a++) begin
                c = centre[a] * UNIT_SCALE;
                v = eye[a] * UNIT_SCALE;
                p = v + back[a] * clamp_dist;
                if (c < p) begin
                    pos = c + half;
                    if (pos > p) pos = p;
                end else begin
                    pos = c - half;
                    if (pos < p) pos = p;
                end
                rel[a] = pos - v;
            end
            facing = rel[0] * back[0] + rel[1] * back[1] + rel[2] * back[2];
            if (facing <= 0) begin
                result.reason = cvc_pkg::REASON_BEHIND;
                return result;
            end

            rq = radius * UNIT_SCALE;
            for (int k = 0; k < 4; k++) begin
                lean = 0;
                for (int a = 0; a < 3; a++) lean += component(plane_normal[k], a) * d[a];
                if (lean + rq < 0) begin
                    result.reason = cvc_pkg::REASON_FRUSTUM;
                    return result;
                end
            end
            result.visible = 1'b1;
            result.reason  = cvc_pkg::REASON_VISIBLE;
            return result;
        endfunction

        function void note_chunk(logic [cvc_pkg::COORD_W-1:0] cx,
                                 logic [cvc_pkg::COORD_W-1:0] cy,
                                 logic [cvc_pkg::COORD_W-1:0] cz);
            pending_verdicts = {pending_verdicts, cull_chunk(cx, cy, cz)};
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [cvc_pkg::OUT_TDATA_W-1:0] word);
            verdict_t want;
            results_seen++;
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("result %0d (tdata %h) with none expected",
                                          results_seen, word));
                return;
            end
            want = pending_verdicts.pop_front();
            if (word[0] !== want.visible)
                report_mismatch($sformatf("result %0d visible %b, want %b",
                                          results_seen, word[0], want.visible));
            if (word[2:1] !== want.reason)
                report_mismatch($sformatf("result %0d cull_reason %0d, want %0d",
                                          results_seen, word[2:1], want.reason));
        endtask
    endclass

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [cvc_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;   // chunk_x, chunk_y, chunk_z, pad
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [cvc_pkg::OUT_TDATA_W-1:0] m_tdata;          // visible, cull_reason, pad
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [cvc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [cvc_pkg::VEC_W-1:0]       cfg_data  = '0;

    chunk_verdict_scoreboard sb = new();
    int chunks_accepted = 0;

    chunk_view_culling DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Sender side. Every task is entered just after a rising edge and
    // leaves just after one, so drives land on a clean cycle boundary.
    // s_tvalid is left high between items; pause_sender and settle lower it.
    // ------------------------------------------------------------------
    task automatic offer_chunk(input int cx, input int cy, input int cz);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cvc_pkg::IN_TDATA_W - 3 * cvc_pkg::COORD_W){1'b0}},
                     cvc_pkg::COORD_W'(cz), cvc_pkg::COORD_W'(cy), cvc_pkg::COORD_W'(cx)};
        do @(posedge aclk); while (!s_tready);
        sb.note_chunk(cvc_pkg::COORD_W'(cx), cvc_pkg::COORD_W'(cy), cvc_pkg::COORD_W'(cz));
        chunks_accepted++;
    endtask

    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold the input off until every predicted verdict has come back;
    // the block is then empty and safe to reconfigure.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // cfg_valid stays high across back-to-back writes; cfg_release drops it.
    task automatic write_reg(input cvc_pkg::cfg_index_t idx,
                             input logic [cvc_pkg::VEC_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, value);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [cvc_pkg::COMP_W-1:0] q1_18(input real r);
        return cvc_pkg::COMP_W'($rtoi(r * 262144.0));
    endfunction

    function automatic logic [cvc_pkg::VEC_W-1:0] pack_dir(input real x, input real y,
                                                           input real z);
        return {q1_18(z), q1_18(y), q1_18(x)};
    endfunction

    // Camera from yaw/pitch: forward f, right r, up u. Side planes lean inward
    // by their half angles, so each normal is sin(h)*f -/+ cos(h)*(r or u).
    task automatic aim_camera(input real yaw, input real pitch,
                              input real half_h, input real half_v);
        real fx, fy, fz, rx, rz, ux, uy, uz, cos_h, sin_h, cos_v, sin_v;
        fx = $cos(pitch) * $sin(yaw);
        fy = $sin(pitch);
        fz = $cos(pitch) * $cos(yaw);
        rx = $cos(yaw);
        rz = -$sin(yaw);
        ux = -$sin(pitch) * $sin(yaw);
        uy = $cos(pitch);
        uz = -$sin(pitch) * $cos(yaw);
        cos_h = $cos(half_h);
        sin_h = $sin(half_h);
        cos_v = $cos(half_v);
        sin_v = $sin(half_v);
        write_reg(cvc_pkg::CFG_BACKWARD, pack_dir(-fx, -fy, -fz));
        write_reg(cvc_pkg::CFG_RIGHT,  pack_dir(sin_h * fx - cos_h * rx, sin_h * fy,
                                                sin_h * fz - cos_h * rz));
        write_reg(cvc_pkg::CFG_LEFT,   pack_dir(sin_h * fx + cos_h * rx, sin_h * fy,
                                                sin_h * fz + cos_h * rz));
        write_reg(cvc_pkg::CFG_TOP,    pack_dir(sin_v * fx - cos_v * ux,
                                                sin_v * fy - cos_v * uy,
                                                sin_v * fz - cos_v * uz));
        write_reg(cvc_pkg::CFG_BOTTOM, pack_dir(sin_v * fx + cos_v * ux,
                                                sin_v * fy + cos_v * uy,
                                                sin_v * fz + cos_v * uz));
    endtask

    // New random view for a random phase. Scalar registers sometimes carry
    // junk above their width, which the block must drop.
    task automatic shuffle_view();
        logic [cvc_pkg::VEC_W-1:0]  junk;
        logic [cvc_pkg::LEN_W-1:0]  len;
        logic [cvc_pkg::DIST_W-1:0] range_q8;
        junk = cvc_pkg::VEC_W'({$urandom, $urandom});
        write_reg(cvc_pkg::CFG_VIEWER_POS, cvc_pkg::VEC_W'({$urandom, $urandom}));

        case ($urandom_range(0, 5))
            0:       len = cvc_pkg::LEN_W'(256);
            1:       len = cvc_pkg::LEN_W'(25600);
            2, 3:    len = cvc_pkg::LEN_W'($urandom_range(256, 2048));
            4:       len = cvc_pkg::LEN_W'($urandom_range(256, 25600));
            default: len = cvc_pkg::LEN_W'($urandom);
        endcase
        write_reg(cvc_pkg::CFG_CHUNK_LEN,
                  $urandom_range(0, 1) ? {junk[cvc_pkg::VEC_W-1:cvc_pkg::LEN_W], len}
                                       : cvc_pkg::VEC_W'(len));

        case ($urandom_range(0, 7))
            0:       range_q8 = '0;
            1:       range_q8 = cvc_pkg::DIST_W'(128000);
            2:       range_q8 = '1;
            default: range_q8 = cvc_pkg::DIST_W'($urandom_range(256, 40000));
        endcase
        write_reg(cvc_pkg::CFG_VIEW_DIST,
                  $urandom_range(0, 1) ? {junk[cvc_pkg::VEC_W-1:cvc_pkg::DIST_W], range_q8}
                                       : cvc_pkg::VEC_W'(range_q8));

        case ($urandom_range(0, 9))
            0: begin
                // raw vectors: noise for the direction and plane datapaths
                write_reg(cvc_pkg::CFG_BACKWARD, cvc_pkg::VEC_W'({$urandom, $urandom}));
                for (int k = 0; k < 4; k++)
                    write_reg(cvc_pkg::cfg_index_t'(int'(cvc_pkg::CFG_RIGHT) + k),
                              cvc_pkg::VEC_W'({$urandom, $urandom}));
            end
            1: begin
                aim_camera(real'($urandom_range(0, 359)) * DEG,
                           (real'($urandom_range(0, 160)) - 80.0) * DEG,
                           real'($urandom_range(15, 75)) * DEG,
                           real'($urandom_range(15, 75)) * DEG);
                // a zero normal must never cull
                write_reg(cvc_pkg::cfg_index_t'(int'(cvc_pkg::CFG_RIGHT)
                                                + $urandom_range(0, 3)), '0);
            end
            default:
                aim_camera(real'($urandom_range(0, 359)) * DEG,
                           (real'($urandom_range(0, 160)) - 80.0) * DEG,
                           real'($urandom_range(15, 75)) * DEG,
                           real'($urandom_range(15, 75)) * DEG);
        endcase
    endtask

    // Mostly chunks around the viewer's own chunk, within reach plus a margin,
    // so all three tests get exercised; the rest is full-range noise.
    task automatic run_random_phase(input int count);
        longint len, span, home;
        int     coord [3];
        int     burst;
        bit     steady;
        steady = ($urandom_range(0, 3) == 0);
        burst  = $urandom_range(1, 24);
        for (int i = 0; i < count; i++) begin
            len = longint'(sb.chunk_len);
            if ($urandom_range(0, 99) < 85) begin
                span = (len == 0) ? 3 : longint'(sb.view_dist) / len + 3;
                if (span > 1023) span = 1023;
                for (int a = 0; a < 3; a++) begin
                    home = (len == 0) ? 0 : sb.component(sb.viewer_pos, a) / len;
                    coord[a] = int'(home) + int'($urandom_range(0, 2 * int'(span))) - int'(span);
                end
            end else begin
                for (int a = 0; a < 3; a++) coord[a] = int'($urandom);
            end
            offer_chunk(coord[0], coord[1], coord[2]);
            burst--;
            if (burst == 0) begin
                if (!steady && $urandom_range(0, 9) < 7) pause_sender($urandom_range(1, 6));
                burst = $urandom_range(1, 24);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: m_tready follows a pattern drawn anew at random intervals
    // (always ready, mostly ready, mostly stalled, toggling). Once, right
    // after 400 accepted chunks, it holds off so the pipeline fills and
    // s_tready has to drop.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int mode;
        int span;
        bit held_off;
        held_off = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            repeat (span) begin
                if (!held_off && chunks_accepted >= 400) begin
                    held_off = 1'b1;
                    m_tready <= 1'b0;
                    repeat (150) @(posedge aclk);
                end
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge aclk);
            end
        end
    end

    // Result monitor: every result transfer is checked against the oldest
    // prediction. Sampled at the edge, before any drive of this step lands.
    always @(posedge aclk) begin
        if (m_tvalid === 1'b1 && m_tready) sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int random_sent;
        int count;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset view: zero direction and normals, so every chunk in range is
        // culled as behind the viewer; corners of the grid are out of range.
        offer_chunk(0, 0, 0);
        offer_chunk(1, 0, 0);
        offer_chunk(6, 0, 0);
        offer_chunk(8, 0, 0);
        offer_chunk(-1024, -1024, -1024);
        offer_chunk(1023, 1023, 1023);
        offer_chunk(-1024, 1023, 0);
        offer_chunk(1023, -1024, -1);

        // Looking down +z with all side planes still zero: nothing is culled
        // by the frustum, the box around the viewer is not behind it.
        settle();
        write_reg(cvc_pkg::CFG_BACKWARD, pack_dir(0.0, 0.0, -1.0));
        cfg_release();
        offer_chunk(0, 0, 3);
        offer_chunk(0, 0, -3);
        offer_chunk(0, 0, 0);
        offer_chunk(5, 5, 0);

        // Proper frustum, 45 deg sideways and 30 deg up/down: visible, each
        // side plane, behind, and the range edge.
        settle();
        aim_camera(0.0, 0.0, 45.0 * DEG, 30.0 * DEG);
        cfg_release();
        offer_chunk(0, 0, 5);
        offer_chunk(4, 0, 1);
        offer_chunk(-4, 0, 1);
        offer_chunk(0, 4, 1);
        offer_chunk(0, -4, 1);
        offer_chunk(0, 0, -5);
        offer_chunk(0, 0, 7);
        offer_chunk(0, 0, 8);

        // Register extremes: zero chunk length (radius 0, every centre at the
        // origin), view distance past its range, extreme vector components.
        settle();
        write_reg(cvc_pkg::CFG_CHUNK_LEN,
                  {{(cvc_pkg::VEC_W - cvc_pkg::LEN_W){1'b1}}, {cvc_pkg::LEN_W{1'b0}}});
        write_reg(cvc_pkg::CFG_VIEW_DIST, '1);
        write_reg(cvc_pkg::CFG_VIEWER_POS, '1);
        write_reg(cvc_pkg::CFG_BACKWARD, {3{20'h7FFFF}});
        for (int k = 0; k < 4; k++)
            write_reg(cvc_pkg::cfg_index_t'(int'(cvc_pkg::CFG_RIGHT) + k), {3{20'h80000}});
        cfg_release();
        offer_chunk(0, 0, 0);
        offer_chunk(1023, 1023, 1023);
        offer_chunk(-1024, -1024, -1024);

        // Widest chunk length the register holds, zero view distance.
        settle();
        write_reg(cvc_pkg::CFG_CHUNK_LEN, cvc_pkg::VEC_W'(15'h7FFF));
        write_reg(cvc_pkg::CFG_VIEW_DIST, '0);
        write_reg(cvc_pkg::CFG_VIEWER_POS, {20'h00000, 20'h80000, 20'h7FFFF});
        cfg_release();
        offer_chunk(0, 0, 0);
        offer_chunk(1, -1, 0);

        // Random phases, each with a fresh view; the block drains in between.
        random_sent = 0;
        while (random_sent < RANDOM_CHUNKS) begin
            count = $urandom_range(60, 140);
            settle();
            shuffle_view();
            cfg_release();
            run_random_phase(count);
            random_sent += count;
        end

        // Drain, then keep watching for stray results before the verdict.
        settle();
        repeat (3 * cvc_pkg::PIPE_DEPTH) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("chunk_view_culling regression: pass");
        else
            $display("chunk_view_culling regression: fail");
        $finish;
    end

    // Hang guard, set far above the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("chunk_view_culling regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/core/cvc_pkg.sv
rtl/core/chunk_view_culling.sv
rtl/core/cvc_checker.sv
tb/sv/chunk_view_culling_test.sv
